// File: design/tcag_pkg.sv
// shared types, constants and helper functions for the tile compositor address generator
// no dependencies; used by every module of the block by scoped names

package tcag_pkg;

  // fixed field widths
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int TILE_W  = 3;
  localparam int NT_W    = 4;
  localparam int SP_W    = 8;
  localparam int FMT_W   = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 24;
  localparam int IDX_W   = 3;

  // clamping limits
  localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd4096;
  localparam logic [NT_W-1:0]  MAX_TILES     = 4'd8;

  // pixel format codes
  localparam logic [FMT_W-1:0] FMT_RGB  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_UYVY = 2'd1;
  localparam logic [FMT_W-1:0] FMT_YUYV = 2'd2;
  localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TILE_COUNT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_TILE_WIDTH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TILE_HEIGHT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DISPLAY_FORMAT = 3'd5;
  localparam logic [IDX_W-1:0] REG_TILE_SPACING   = 3'd6;

  // mask for the rgb part of an element
  localparam logic [DATA_W-1:0] RGB_MASK = 32'h00FF_FFFF;

  // configuration register set
  typedef struct packed {
    logic [DIM_W-1:0] display_width;
    logic [DIM_W-1:0] display_height;
    logic [NT_W-1:0]  tile_count;
    logic [DIM_W-1:0] tile_width;
    logic [DIM_W-1:0] tile_height;
    logic [FMT_W-1:0] display_format;
    logic [SP_W-1:0]  tile_spacing;
  } cfg_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  col;
    logic [CNT_W-1:0]  row;
    logic [TILE_W-1:0] tile;
    logic              yuv;
    logic              mismatch;
    logic              last;
  } item_t;

  // sizes above the limit are taken as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
  endfunction

  // tile count of zero means one, above the limit means the limit
  function automatic logic [NT_W-1:0] eff_tiles(input logic [NT_W-1:0] v);
    logic [NT_W-1:0] r;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > MAX_TILES) begin
      r = MAX_TILES;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic is_yuv(input logic [FMT_W-1:0] f);
    return (f == FMT_UYVY) || (f == FMT_YUYV);
  endfunction

endpackage

// File: design/tcag_front.sv
// front end: tracks column, row and tile counters and classifies each request
// depends on tcag_pkg

module tcag_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcag_pkg::cfg_t             cfg,
  input  logic                       accept,
  input  logic [tcag_pkg::DATA_W-1:0] pixel_data,
  input  logic [tcag_pkg::FMT_W-1:0]  source_format,
  output tcag_pkg::item_t            item
);

  logic [tcag_pkg::CNT_W-1:0]  col_r, col_nxt;
  logic [tcag_pkg::CNT_W-1:0]  row_r, row_nxt;
  logic [tcag_pkg::TILE_W-1:0] tile_r, tile_nxt;

  logic [tcag_pkg::DIM_W-1:0]  tw_c, cols_raw, cols, rows;
  logic [tcag_pkg::NT_W-1:0]   n;
  logic                        yuv;
  logic [tcag_pkg::CNT_W-1:0]  col_max, row_max, col_c, row_c;
  logic [tcag_pkg::TILE_W-1:0] tile_max, tile_c;
  logic [tcag_pkg::DIM_W-1:0]  col_inc, row_inc;
  logic [tcag_pkg::NT_W-1:0]   tile_inc;

  // effective tile geometry in elements
  always_comb begin
    yuv      = tcag_pkg::is_yuv(cfg.display_format);
    tw_c     = tcag_pkg::clamp_dim(cfg.tile_width);
    cols_raw = yuv ? {1'b0, tw_c[tcag_pkg::DIM_W-1:1]} : tw_c;
    cols     = (cols_raw == '0) ? 13'd1 : cols_raw;
    rows     = tcag_pkg::clamp_dim(cfg.tile_height);
    if (rows == '0) begin
      rows = 13'd1;
    end
    n        = tcag_pkg::eff_tiles(cfg.tile_count);
    col_max  = tcag_pkg::CNT_W'(cols - 13'd1);
    row_max  = tcag_pkg::CNT_W'(rows - 13'd1);
    tile_max = tcag_pkg::TILE_W'(n - 4'd1);
  end

  // pull counters back inside the current geometry
  always_comb begin
    col_c  = ({1'b0, col_r} >= cols) ? col_max : col_r;
    row_c  = ({1'b0, row_r} >= rows) ? row_max : row_r;
    tile_c = ({1'b0, tile_r} >= n) ? tile_max : tile_r;
  end

  // counter advance in raster order, tile after tile
  always_comb begin
    col_inc  = {1'b0, col_c} + 13'd1;
    row_inc  = {1'b0, row_c} + 13'd1;
    tile_inc = {1'b0, tile_c} + 4'd1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    tile_nxt = tile_r;
    if (accept) begin
      if (col_inc < cols) begin
        col_nxt  = col_inc[tcag_pkg::CNT_W-1:0];
        row_nxt  = row_c;
        tile_nxt = tile_c;
      end else begin
        col_nxt = '0;
        if (row_inc < rows) begin
          row_nxt  = row_inc[tcag_pkg::CNT_W-1:0];
          tile_nxt = tile_c;
        end else begin
          row_nxt  = '0;
          tile_nxt = (tile_inc < n) ? tile_inc[tcag_pkg::TILE_W-1:0] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      tile_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      tile_r <= tile_nxt;
    end
  end

  // classified request
  always_comb begin
    item.data     = yuv ? pixel_data : (pixel_data & tcag_pkg::RGB_MASK);
    item.col      = col_c;
    item.row      = row_c;
    item.tile     = tile_c;
    item.yuv      = yuv;
    item.mismatch = (source_format != cfg.display_format) ||
                    (cfg.display_format == tcag_pkg::FMT_NONE);
    item.last     = (col_c == col_max) && (row_c == row_max) && (tile_c == tile_max);
  end

endmodule

// File: design/tcag_queue.sv
// two-entry request queue between front and back
// depends on tcag_pkg

module tcag_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcag_pkg::item_t push_item,
  input  logic            pop,
  output tcag_pkg::item_t head,
  output logic            not_empty,
  output logic            not_full
);

  tcag_pkg::item_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head      = entry_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign not_full  = (count_r != 2'd2);

endmodule

// File: design/tcag_back.sv
// back end: four-stage address pipeline with bounds check and output register
// depends on tcag_pkg

module tcag_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcag_pkg::cfg_t              cfg,
  input  tcag_pkg::item_t             head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcag_pkg::ADDR_W-1:0] out_write_address,
  output logic [tcag_pkg::DATA_W-1:0] out_write_data,
  output logic                        out_write_enable,
  output logic                        out_status,
  output logic                        out_frame_last
);

  localparam int SW = 28;

  // control carried alongside each request
  typedef struct packed {
    logic [tcag_pkg::DATA_W-1:0] data;
    logic                        yuv;
    logic                        mismatch;
    logic                        last;
  } ctl_t;

  logic advance;

  logic [tcag_pkg::DIM_W-1:0] w, h, tw, th, wrow;
  logic [tcag_pkg::NT_W-1:0]  n;

  // stage 1 signals
  logic signed [13:0]         dh, dh_adj, hh;
  logic signed [SW-1:0]       top;
  logic [24:0]                row_off;
  logic [16:0]                span, stride;
  logic                       s1_v_r;
  ctl_t                       s1_ctl_r;
  logic signed [SW-1:0]       s1_top_r;
  logic [24:0]                s1_row_off_r;
  logic [16:0]                s1_span_r, s1_stride_r;
  logic [tcag_pkg::CNT_W-1:0] s1_col_r;

  // stage 2 signals
  logic signed [17:0]         lraw, lraw_adj, lhalf, left;
  logic [24:0]                size;
  logic                       s2_v_r;
  ctl_t                       s2_ctl_r;
  logic signed [SW-1:0]       s2_top_r;
  logic signed [17:0]         s2_left_r;
  logic [24:0]                s2_row_off_r, s2_size_r;
  logic [tcag_pkg::CNT_W-1:0] s2_col_r;

  // stage 3 signals
  logic signed [SW-1:0]       origin, origin_adj, origin_h;
  logic [25:0]                rc;
  logic                       s3_v_r;
  ctl_t                       s3_ctl_r;
  logic signed [SW-1:0]       s3_origin_r;
  logic [25:0]                s3_rc_r;
  logic [24:0]                s3_size_r;

  // stage 4 signals
  logic signed [SW-1:0]       addr;
  logic                       in_bounds, wr;

  // whole pipe moves when the output register is free or being taken
  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  // clamped geometry; user keeps it stable while requests in flight, unchecked
  always_comb begin
    w    = tcag_pkg::clamp_dim(cfg.display_width);
    h    = tcag_pkg::clamp_dim(cfg.display_height);
    tw   = tcag_pkg::clamp_dim(cfg.tile_width);
    th   = tcag_pkg::clamp_dim(cfg.tile_height);
    n    = tcag_pkg::eff_tiles(cfg.tile_count);
    wrow = tcag_pkg::is_yuv(cfg.display_format) ?
           {1'b0, w[tcag_pkg::DIM_W-1:1]} : w;
  end

  // stage 1: vertical offset, row offset, tile row span and tile stride
  always_comb begin
    dh      = $signed({1'b0, h}) - $signed({1'b0, th});
    dh_adj  = dh + 14'(dh[13]);
    hh      = dh_adj >>> 1;
    top     = SW'(hh) * $signed({15'd0, w});
    row_off = 25'(head.row) * 25'(wrow);
    span    = 17'(n) * 17'(tw) + 17'(n - 4'd1) * 17'(cfg.tile_spacing);
    stride  = 17'(head.tile) * (17'(tw) + 17'(cfg.tile_spacing));
  end

  // stage 2: horizontal origin of the tile row and buffer size
  always_comb begin
    lraw     = $signed({5'd0, w}) - $signed({1'b0, s1_span_r});
    lraw_adj = lraw + 18'(lraw[17]);
    lhalf    = lraw_adj >>> 1;
    left     = lhalf + $signed({1'b0, s1_stride_r});
    size     = 25'(wrow) * 25'(h);
  end

  // stage 3: tile origin, halved toward zero for macropixel formats
  always_comb begin
    origin     = s2_top_r + SW'(s2_left_r);
    origin_adj = origin + SW'(origin[SW-1]);
    origin_h   = s2_ctl_r.yuv ? (origin_adj >>> 1) : origin;
    rc         = 26'(s2_row_off_r) + 26'(s2_col_r);
  end

  // stage 4: final address and bounds check
  always_comb begin
    addr      = s3_origin_r + $signed({2'b00, s3_rc_r});
    in_bounds = !addr[SW-1] && (addr < $signed({3'b000, s3_size_r}));
    wr        = !s3_ctl_r.mismatch && in_bounds;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_v_r    <= head_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      out_valid <= s3_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl_r          <= '{data: head.data, yuv: head.yuv,
                             mismatch: head.mismatch, last: head.last};
      s1_top_r          <= top;
      s1_row_off_r      <= row_off;
      s1_span_r         <= span;
      s1_stride_r       <= stride;
      s1_col_r          <= head.col;

      s2_ctl_r          <= s1_ctl_r;
      s2_top_r          <= s1_top_r;
      s2_left_r         <= left;
      s2_row_off_r      <= s1_row_off_r;
      s2_size_r         <= size;
      s2_col_r          <= s1_col_r;

      s3_ctl_r          <= s2_ctl_r;
      s3_origin_r       <= origin_h;
      s3_rc_r           <= rc;
      s3_size_r         <= s2_size_r;

      out_write_address <= wr ? addr[tcag_pkg::ADDR_W-1:0] : '0;
      out_write_data    <= wr ? s3_ctl_r.data : '0;
      out_write_enable  <= wr;
      out_status        <= s3_ctl_r.mismatch;
      out_frame_last    <= s3_ctl_r.last;
    end
  end

endmodule

// File: design/tile_compositor_address_gen_unit.sv
// tile compositor address generator: throughput one element per cycle while the
// output is not stalled; the front counters and the address pipeline each take a
// request every cycle when not stalled, a two-entry queue absorbs output stalls
// synchronous active-low reset clears counters, queue and pipeline valid flags,
// and returns the configuration registers to their power-on values
// depends on tcag_pkg, tcag_front, tcag_queue, tcag_back

module tile_compositor_address_gen_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tcag_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tcag_pkg::DIM_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcag_pkg::DATA_W-1:0] in_pixel_data,
  input  logic [tcag_pkg::FMT_W-1:0]  in_source_format,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcag_pkg::ADDR_W-1:0] out_write_address,
  output logic [tcag_pkg::DATA_W-1:0] out_write_data,
  output logic                        out_write_enable,
  output logic                        out_status,
  output logic                        out_frame_last
);

  tcag_pkg::cfg_t  cfg_r, cfg_nxt;
  tcag_pkg::item_t front_item, head;
  logic            accept, head_valid, pop;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        tcag_pkg::REG_DISPLAY_WIDTH:  cfg_nxt.display_width  = cfg_wr_data;
        tcag_pkg::REG_DISPLAY_HEIGHT: cfg_nxt.display_height = cfg_wr_data;
        tcag_pkg::REG_TILE_COUNT:     cfg_nxt.tile_count     = cfg_wr_data[tcag_pkg::NT_W-1:0];
        tcag_pkg::REG_TILE_WIDTH:     cfg_nxt.tile_width     = cfg_wr_data;
        tcag_pkg::REG_TILE_HEIGHT:    cfg_nxt.tile_height    = cfg_wr_data;
        tcag_pkg::REG_DISPLAY_FORMAT: cfg_nxt.display_format = cfg_wr_data[tcag_pkg::FMT_W-1:0];
        tcag_pkg::REG_TILE_SPACING:   cfg_nxt.tile_spacing   = cfg_wr_data[tcag_pkg::SP_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_width  <= 13'd1920;
      cfg_r.display_height <= 13'd1080;
      cfg_r.tile_count     <= 4'd1;
      cfg_r.tile_width     <= 13'd640;
      cfg_r.tile_height    <= 13'd640;
      cfg_r.display_format <= tcag_pkg::FMT_RGB;
      cfg_r.tile_spacing   <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input request accepted whenever the queue has room
  assign accept = in_valid && in_ready;

  tcag_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .pixel_data    (in_pixel_data),
    .source_format (in_source_format),
    .item          (front_item)
  );

  tcag_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .not_full  (in_ready)
  );

  tcag_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_enable  (out_write_enable),
    .out_status        (out_status),
    .out_frame_last    (out_frame_last)
  );

endmodule

// File: tb/sv/tcag_write_check_pkg.sv
// display write predictor and scoreboard for the tile compositor address generator bench
// depends on tcag_pkg for field widths, format codes and register indexes

package tcag_write_check_pkg;

  import tcag_pkg::*;

  // one display write as seen on the result channel
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              enable;
    logic              status;
    logic              frame_last;
  } display_write_t;

  class display_write_scoreboard;

    cfg_t           regs;
    longint         column_pos;
    longint         row_pos;
    longint         tile_pos;
    display_write_t pending_writes[$];
    int unsigned    mismatches;

    // power-on register set and counters at zero
    function new();
      regs.display_width  = 13'd1920;
      regs.display_height = 13'd1080;
      regs.tile_count     = 4'd1;
      regs.tile_width     = 13'd640;
      regs.tile_height    = 13'd640;
      regs.display_format = FMT_RGB;
      regs.tile_spacing   = 8'd10;
      column_pos = 0;
      row_pos    = 0;
      tile_pos   = 0;
      mismatches = 0;
    endfunction

    // sizes beyond the supported dimension saturate
    static function longint bounded_size(logic [DIM_W-1:0] v);
      if (v > MAX_DIMENSION) begin
        return longint'(MAX_DIMENSION);
      end
      return longint'(v);
    endfunction

    // zero tiles means one, too many means the maximum
    static function longint tiles_in_row(logic [NT_W-1:0] v);
      if (v == '0) begin
        return 1;
      end
      if (v > MAX_TILES) begin
        return longint'(MAX_TILES);
      end
      return longint'(v);
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_DISPLAY_WIDTH:  regs.display_width  = val;
        REG_DISPLAY_HEIGHT: regs.display_height = val;
        REG_TILE_COUNT:     regs.tile_count     = val[NT_W-1:0];
        REG_TILE_WIDTH:     regs.tile_width     = val;
        REG_TILE_HEIGHT:    regs.tile_height    = val;
        REG_DISPLAY_FORMAT: regs.display_format = val[FMT_W-1:0];
        REG_TILE_SPACING:   regs.tile_spacing   = val[SP_W-1:0];
        default: ;
      endcase
    endfunction

    // work out the display write for one accepted request and step the counters
    function void note_pixel(logic [DATA_W-1:0] pixel, logic [FMT_W-1:0] src_fmt);
      longint         w, h, tw, th, n, sp, cols, rows;
      longint         top, left, base, addr, span;
      logic           yuv;
      display_write_t want;
      yuv  = (regs.display_format == FMT_UYVY) || (regs.display_format == FMT_YUYV);
      w    = bounded_size(regs.display_width);
      h    = bounded_size(regs.display_height);
      tw   = bounded_size(regs.tile_width);
      th   = bounded_size(regs.tile_height);
      n    = tiles_in_row(regs.tile_count);
      sp   = longint'(regs.tile_spacing);
      cols = yuv ? tw / 2 : tw;
      if (cols < 1) cols = 1;
      rows = (th < 1) ? 1 : th;

      // counters pulled back inside a layout that shrank
      if (column_pos >= cols) column_pos = cols - 1;
      if (row_pos >= rows) row_pos = rows - 1;
      if (tile_pos >= n) tile_pos = n - 1;

      // tiles centred vertically, row of tiles centred horizontally
      top  = ((h - th) / 2) * w;
      left = (w - n * tw - (n - 1) * sp) / 2 + tile_pos * (tw + sp);
      if (yuv) begin
        base = (top + left) / 2 + row_pos * (w / 2);
        span = (w / 2) * h;
      end else begin
        base = top + left + row_pos * w;
        span = w * h;
      end
      addr = base + column_pos;

      want            = '0;
      want.status     = (src_fmt != regs.display_format) ||
                        (regs.display_format == FMT_NONE);
      want.frame_last = (column_pos == cols - 1) && (row_pos == rows - 1) &&
                        (tile_pos == n - 1);
      // no write on a format mismatch or outside the buffer
      if (!want.status && addr >= 0 && addr < span) begin
        want.address = addr[ADDR_W-1:0];
        want.data    = yuv ? pixel : (pixel & RGB_MASK);
        want.enable  = 1'b1;
      end
      pending_writes.push_back(want);

      // raster order inside a tile, then the next tile, wrapping after the last
      if (column_pos + 1 < cols) begin
        column_pos++;
      end else begin
        column_pos = 0;
        if (row_pos + 1 < rows) begin
          row_pos++;
        end else begin
          row_pos  = 0;
          tile_pos = (tile_pos + 1 < n) ? tile_pos + 1 : 0;
        end
      end
    endfunction

    // compare a result against the oldest predicted write
    function void check_write(display_write_t got);
      display_write_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected display write: addr %h data %h we %b st %b last %b",
                   got.address, got.data, got.enable, got.status, got.frame_last);
        end
        return;
      end
      want = pending_writes.pop_front();
      if (got.address !== want.address || got.data !== want.data ||
          got.enable !== want.enable || got.status !== want.status ||
          got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("display write mismatch: exp addr %h data %h we %b st %b last %b",
                   want.address, want.data, want.enable, want.status, want.frame_last);
          $display("                        got addr %h data %h we %b st %b last %b",
                   got.address, got.data, got.enable, got.status, got.frame_last);
        end
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

  endclass

endpackage

// File: tb/sv/tb_tile_compositor_address_gen_unit.sv
// top-level bench for tile_compositor_address_gen_unit: directed layouts, then random layouts
// with random pixel streams, random gaps and output stalls, checked against a predictor
// depends on tcag_pkg, tcag_write_check_pkg and the block's rtl

module tb_tile_compositor_address_gen_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import tcag_pkg::*;
  import tcag_write_check_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PIXELS = 650;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              cfg_wr_en        = 1'b0;
  logic [IDX_W-1:0]  cfg_index        = '0;
  logic [DIM_W-1:0]  cfg_wr_data      = '0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_pixel_data    = '0;
  logic [FMT_W-1:0]  in_source_format = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [ADDR_W-1:0] out_write_address;
  logic [DATA_W-1:0] out_write_data;
  logic              out_write_enable;
  logic              out_status;
  logic              out_frame_last;

  display_write_scoreboard board;
  int unsigned             pixels_sent  = 0;
  int unsigned             quiet_cycles = 0;

  always #5 clk = ~clk;

  tile_compositor_address_gen_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_data     (in_pixel_data),
    .in_source_format  (in_source_format),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_enable  (out_write_enable),
    .out_status        (out_status),
    .out_frame_last    (out_frame_last)
  );

  // stretch of the stream with no gaps on either side
  function automatic logic steady_stretch();
    return (pixels_sent >= 300) && (pixels_sent < 420);
  endfunction

  // random back-pressure on the result channel
  always @(posedge clk) begin
    out_ready <= steady_stretch() || ($urandom_range(99) >= 19);
  end

  // result check and watchdog on handshake activity
  always @(posedge clk) begin : monitor
    display_write_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.address    = out_write_address;
        seen.data       = out_write_data;
        seen.enable     = out_write_enable;
        seen.status     = out_status;
        seen.frame_last = out_frame_last;
        board.check_write(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("** tile_compositor_address_gen_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  // one register write, predictor follows at the same edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    board.set_register(idx, val);
  endtask

  // full register set for one layout
  task automatic program_layout(input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                                input logic [NT_W-1:0] n, input logic [DIM_W-1:0] tw,
                                input logic [DIM_W-1:0] th, input logic [FMT_W-1:0] fmt,
                                input logic [SP_W-1:0] sp);
    write_reg(REG_DISPLAY_WIDTH, dw);
    write_reg(REG_DISPLAY_HEIGHT, dh);
    write_reg(REG_TILE_COUNT, DIM_W'(n));
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_DISPLAY_FORMAT, DIM_W'(fmt));
    write_reg(REG_TILE_SPACING, DIM_W'(sp));
    // unused index, must leave the set untouched
    write_reg(REG_SPARE, DIM_W'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one pixel request, with an optional random gap ahead of it
  task automatic send_pixel(input logic [DATA_W-1:0] pixel, input logic [FMT_W-1:0] fmt);
    while (!steady_stretch() && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pixel_data    <= pixel;
    in_source_format <= fmt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(pixel, fmt);
    pixels_sent++;
  endtask

  // wait for every predicted write, then let the pipeline settle
  task automatic drain_writes();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] dw, dh, tw, th;
    logic [NT_W-1:0]  n;
    logic [FMT_W-1:0] fmt, src;
    logic [SP_W-1:0]  sp;
    int               count, roll, random_sent;

    board = new();
    random_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on layout: data extremes and two mismatching source formats
    send_pixel(32'h0000_0000, FMT_RGB);
    send_pixel(32'hFFFF_FFFF, FMT_RGB);
    send_pixel(32'hA5A5_A5A5, FMT_UYVY);
    send_pixel(32'h5A5A_5A5A, FMT_NONE);
    drain_writes();

    // two small rgb tiles, one whole frame: tile change, frame end
    program_layout(13'd16, 13'd6, 4'd2, 13'd4, 13'd2, FMT_RGB, 8'd2);
    for (int i = 0; i < 16; i++) begin
      send_pixel($urandom, FMT_RGB);
    end
    drain_writes();

    // macropixel layout, halved widths, plus the wrap after the frame end
    program_layout(13'd12, 13'd4, 4'd1, 13'd4, 13'd2, FMT_UYVY, 8'd0);
    for (int i = 0; i < 5; i++) begin
      send_pixel($urandom, FMT_UYVY);
    end
    drain_writes();

    // random layouts, each with a random pixel stream
    while (random_sent < RANDOM_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        fmt = FMT_W'($urandom_range(2));
        case ($urandom_range(5))
          0: begin
            // largest legal frame and tile
            dw = 13'd4096; dh = 13'd4096; n = 4'd1; tw = 13'd4096; th = 13'd4096;
            sp = 8'd255;
          end
          1: begin
            // every size over the limit, unused display format
            dw = 13'd8191; dh = 13'd8191; n = 4'd15; tw = 13'd8191; th = 13'd8191;
            sp = 8'd255; fmt = FMT_NONE;
          end
          2: begin
            // smallest legal layout
            dw = 13'd2; dh = 13'd2; n = 4'd1; tw = 13'd2; th = 13'd1; sp = 8'd0;
          end
          3: begin
            // all sizes zero
            dw = 13'd0; dh = 13'd0; n = 4'd0; tw = 13'd0; th = 13'd0; sp = 8'd0;
          end
          4: begin
            // tiles wider and taller than the frame, writes fall outside
            dw = 13'd8; dh = 13'd4; n = 4'd3; tw = 13'd16; th = 13'd8; sp = 8'd5;
          end
          default: begin
            // odd tile width that halves to nothing
            dw = 13'd6; dh = 13'd4; n = 4'd2; tw = 13'd1; th = 13'd2; sp = 8'd3;
            fmt = FMT_UYVY;
          end
        endcase
      end else begin
        dw   = DIM_W'($urandom_range(64, 2));
        dh   = DIM_W'($urandom_range(48, 2));
        roll = $urandom_range(99);
        if (roll < 6) begin
          n = NT_W'($urandom_range(15, 9));
        end else if (roll < 10) begin
          n = 4'd0;
        end else begin
          n = NT_W'($urandom_range(8, 1));
        end
        tw  = ($urandom_range(99) < 10) ? DIM_W'($urandom_range(15, 1)) :
                                          DIM_W'(2 * $urandom_range(8, 1));
        th  = ($urandom_range(99) < 5) ? 13'd0 : DIM_W'($urandom_range(6, 1));
        fmt = ($urandom_range(99) < 5) ? FMT_NONE : FMT_W'($urandom_range(2));
        sp  = ($urandom_range(99) < 8) ? 8'd255 : SP_W'($urandom_range(7));
      end
      program_layout(dw, dh, n, tw, th, fmt, sp);

      // mostly matching source format, some mismatching requests
      count = $urandom_range(90, 20);
      for (int i = 0; i < count; i++) begin
        if (fmt != FMT_NONE && $urandom_range(99) < 85) begin
          src = fmt;
        end else begin
          src = FMT_W'($urandom_range(3));
        end
        send_pixel($urandom, src);
      end
      random_sent += count;
      drain_writes();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** tile_compositor_address_gen_unit: PASSED **");
    end else begin
      $display("** tile_compositor_address_gen_unit: FAILED **");
    end
    $finish;
  end

endmodule
